/* sv/particle_integrator_step_macros.svh */
// Assertion macros shared by the integrator RTL.
// In simulation they expand to concurrent assertions; for synthesis they vanish.
`ifndef PARTICLE_INTEGRATOR_STEP_MACROS_SVH
`define PARTICLE_INTEGRATOR_STEP_MACROS_SVH

`ifndef SYNTHESIS
// Property checked while out of reset.
`define PIS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked at every edge, reset included.
`define PIS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PIS_ASSERT(lbl, clk, rst_n, prop, msg)
`define PIS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* sv/pis_pkg.sv */
`timescale 1ns / 1ps

package pis_pkg;

  // Number format: signed Q16.16 words, unsigned Q15.16 factors one bit narrower.
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int UFRAC_W   = WORD_BITS - 1;
  localparam int STEP_W    = 16;
  localparam int TAG_W     = 16;
  localparam int PROD_W    = WORD_BITS + UFRAC_W;
  localparam int SUM_W     = PROD_W + 1;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic        [WORD_BITS-1:0] mag_t;
  typedef logic        [UFRAC_W-1:0]   ufrac_t;
  typedef logic        [STEP_W-1:0]    step_t;
  typedef logic        [TAG_W-1:0]     tag_t;
  typedef logic        [PROD_W-1:0]    prod_t;
  typedef logic        [SUM_W-1:0]     sum_t;

  typedef enum logic [1:0] {
    M_SYMP   = 2'd0,
    M_VERLET = 2'd1,
    M_FIRST  = 2'd2,
    M_DAMP   = 2'd3
  } method_e;

  typedef enum logic [1:0] {
    CFG_METHOD = 2'd0,
    CFG_STEP   = 2'd1,
    CFG_GAMMA  = 2'd2
  } cfg_idx_e;

  localparam method_e METHOD_RST = M_SYMP;
  localparam step_t   STEP_RST   = 16'd655;
  localparam ufrac_t  GAMMA_RST  = 31'd65536;

  localparam word_t SMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t SMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Rounding offsets and saturation limits on the widened product.
  localparam sum_t RND_FULL = sum_t'(1) << (FRAC_BITS - 1);
  localparam sum_t RND_HALF = sum_t'(1) << FRAC_BITS;
  localparam sum_t NEG_LIM  = sum_t'(1) << (WORD_BITS - 1);
  localparam sum_t POS_LIM  = NEG_LIM - sum_t'(1);

  typedef struct packed {
    logic   func;
    word_t  position;
    word_t  velocity;
    word_t  force_req;
    ufrac_t inv_mass;
    logic   fixed;
    tag_t   item_tag;
    logic   last;
  } in_t;

  typedef struct packed {
    word_t new_position;
    word_t new_velocity;
    tag_t  tag_out;
    logic  last_out;
  } out_t;

  // Per-request control decoded at entry and carried along the pipeline.
  typedef struct packed {
    logic kick_v;      // velocity gets a kick added
    logic damp_v;      // velocity replaced by the damped force term
    logic upd_x;       // position is advanced
    logic half_kick;   // kick uses h/2
    logic verlet_pos;  // Verlet position pass with the h*h/2 term
  } ctrl_t;

  typedef struct packed {
    tag_t tag;
    logic last;
  } side_t;

  // Round a magnitude product to nearest (ties away from zero), apply the
  // sign and saturate. Half selects the extra shift for a factor of one half.
  function automatic word_t rnd_sat(input prod_t prod, input logic neg, input logic half);
    sum_t  sum;
    sum_t  q;
    word_t r;
    sum = {1'b0, prod} + (half ? RND_HALF : RND_FULL);
    q   = half ? (sum >> (FRAC_BITS + 1)) : (sum >> FRAC_BITS);
    if (neg) begin
      if (q > NEG_LIM) r = SMIN;
      else             r = -word_t'(q[WORD_BITS-1:0]);
    end else begin
      if (q > POS_LIM) r = SMAX;
      else             r = word_t'(q[WORD_BITS-1:0]);
    end
    return r;
  endfunction

  function automatic word_t sat_add(input word_t a, input word_t b);
    logic signed [WORD_BITS:0] s;
    word_t r;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) r = s[WORD_BITS] ? SMIN : SMAX;
    else                                r = s[WORD_BITS-1:0];
    return r;
  endfunction

  function automatic word_t sat_neg(input word_t a);
    word_t r;
    if (a == SMIN) r = SMAX;
    else           r = -a;
    return r;
  endfunction

endpackage

/* sv/pis_mul.sv */
`timescale 1ns / 1ps

// Registered sign-magnitude multiplier: signed word times unsigned factor.
module pis_mul import pis_pkg::*; (
  input  logic   clk_i,
  input  word_t  a_i,
  input  ufrac_t b_i,
  output prod_t  prod_o,
  output logic   neg_o
);

  mag_t  mag;
  prod_t prod_d, prod_q;
  logic  neg_d, neg_q;

  // Magnitude of the signed operand; the most negative word maps to 2^31.
  always_comb begin
    mag    = a_i[WORD_BITS-1] ? mag_t'(-a_i) : mag_t'(a_i);
    neg_d  = a_i[WORD_BITS-1];
    prod_d = prod_t'(mag) * prod_t'(b_i);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    neg_q  <= neg_d;
  end

  assign prod_o = prod_q;
  assign neg_o  = neg_q;

endmodule

/* sv/particle_integrator_step.sv */
`timescale 1ns / 1ps
`include "particle_integrator_step_macros.svh"

// Particle integrator step. One request (one component of one particle) is
// taken on every clock at which start_i is high; busy_o never rises, so the
// block accepts a request each cycle. The result appears on res_o for exactly
// one cycle with done_o high, and must be captured then: it cannot be held
// off. The pipeline is a chain of three registered 32x31 multiplies (acceleration,
// kick, position step), each followed by a rounding stage and a saturating stage,
// then the output register. The user must write method, step size and inverse
// friction through the cfg port only while no request is in flight; the block
// does not enforce this.
module particle_integrator_step import pis_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  output logic         busy_o,
  input  in_t          req_i,
  output logic         done_o,
  output out_t         res_o,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  ufrac_t       cfg_wdata_i
);

  localparam int DEPTH = 8;

  method_e method_q;
  step_t   step_q;
  ufrac_t  gamma_q;
  ufrac_t  step_ext;

  logic             accept;
  logic [DEPTH-1:0] vld_q;
  logic             done_q;
  out_t             res_q;
  ctrl_t            ctl_d;

  ctrl_t ctl1_q, ctl2_q, ctl3_q, ctl4_q, ctl5_q, ctl6_q, ctl7_q, ctl8_q;
  side_t sd1_q, sd2_q, sd3_q, sd4_q, sd5_q, sd6_q, sd7_q, sd8_q;
  word_t x1_q, x2_q, x3_q, x4_q, x5_q, x6_q, x7_q, x8_q;
  word_t v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;
  word_t acc2_q;
  word_t pa2_q, pa3_q, pa4_q, pa5_q, pa6_q, pa7_q;
  word_t t4_q, t5_q, t8_q;
  word_t c7_q;

  ufrac_t fa_fac;
  prod_t  fa_prod, vh_prod, kb_prod, xc_prod;
  logic   fa_neg, vh_neg, kb_neg, xc_neg;
  word_t  xc_opnd;

  // The pipeline never stalls, so every request is taken.
  assign busy_o   = 1'b0;
  assign accept   = start_i && !busy_o;
  assign step_ext = {{(UFRAC_W-STEP_W){1'b0}}, step_q};

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q <= METHOD_RST;
      step_q   <= STEP_RST;
      gamma_q  <= GAMMA_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_METHOD: method_q <= method_e'(cfg_wdata_i[1:0]);
        CFG_STEP:   step_q   <= cfg_wdata_i[STEP_W-1:0];
        CFG_GAMMA:  gamma_q  <= cfg_wdata_i;
        default:    ;
      endcase
    end
  end

  // Decode what the method does to this request.
  always_comb begin
    ctl_d = '0;
    unique case (method_q)
      M_SYMP: begin
        ctl_d.kick_v = 1'b1;
        ctl_d.upd_x  = 1'b1;
      end
      M_VERLET: begin
        ctl_d.kick_v     = req_i.func;
        ctl_d.half_kick  = req_i.func;
        ctl_d.upd_x      = !req_i.func;
        ctl_d.verlet_pos = !req_i.func;
      end
      M_FIRST: begin
        ctl_d.upd_x = 1'b1;
      end
      M_DAMP: begin
        ctl_d.damp_v = 1'b1;
        ctl_d.upd_x  = 1'b1;
      end
      default: ctl_d = '0;
    endcase
    if (req_i.fixed) begin
      ctl_d.kick_v = 1'b0;
      ctl_d.damp_v = 1'b0;
      ctl_d.upd_x  = 1'b0;
    end
  end

  // Stage 1 multiplies: force by inverse mass (or inverse friction), velocity by h.
  assign fa_fac = (method_q == M_DAMP) ? gamma_q : req_i.inv_mass;

  pis_mul u_mul_force (
    .clk_i  (clk_i),
    .a_i    (req_i.force_req),
    .b_i    (fa_fac),
    .prod_o (fa_prod),
    .neg_o  (fa_neg)
  );

  pis_mul u_mul_vel (
    .clk_i  (clk_i),
    .a_i    (req_i.velocity),
    .b_i    (step_ext),
    .prod_o (vh_prod),
    .neg_o  (vh_neg)
  );

  // Stage 3 multiply: acceleration by h.
  pis_mul u_mul_kick (
    .clk_i  (clk_i),
    .a_i    (acc2_q),
    .b_i    (step_ext),
    .prod_o (kb_prod),
    .neg_o  (kb_neg)
  );

  // Stage 6 multiply: new velocity by h, or h*a by h for the Verlet position pass.
  assign xc_opnd = ctl5_q.verlet_pos ? t5_q : v5_q;

  pis_mul u_mul_step (
    .clk_i  (clk_i),
    .a_i    (xc_opnd),
    .b_i    (step_ext),
    .prod_o (xc_prod),
    .neg_o  (xc_neg)
  );

  // Valid bits travel alongside the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[DEPTH-2:0], accept};
      done_q <= vld_q[DEPTH-1];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    // Stage 1: capture the request.
    ctl1_q <= ctl_d;
    sd1_q  <= '{tag: req_i.item_tag, last: req_i.last};
    x1_q   <= req_i.position;
    v1_q   <= req_i.velocity;

    // Stage 2: round the first products.
    ctl2_q <= ctl1_q;
    sd2_q  <= sd1_q;
    x2_q   <= x1_q;
    v2_q   <= v1_q;
    acc2_q <= rnd_sat(fa_prod, fa_neg, 1'b0);
    pa2_q  <= rnd_sat(vh_prod, vh_neg, 1'b0);

    // Stage 3: damped velocity is the negated force term.
    ctl3_q <= ctl2_q;
    sd3_q  <= sd2_q;
    x3_q   <= x2_q;
    v3_q   <= ctl2_q.damp_v ? sat_neg(acc2_q) : v2_q;
    pa3_q  <= pa2_q;

    // Stage 4: round the kick, with h/2 for the Verlet half kick.
    ctl4_q <= ctl3_q;
    sd4_q  <= sd3_q;
    x4_q   <= x3_q;
    v4_q   <= v3_q;
    pa4_q  <= pa3_q;
    t4_q   <= rnd_sat(kb_prod, kb_neg, ctl3_q.half_kick);

    // Stage 5: apply the velocity kick.
    ctl5_q <= ctl4_q;
    sd5_q  <= sd4_q;
    x5_q   <= x4_q;
    v5_q   <= ctl4_q.kick_v ? sat_add(v4_q, t4_q) : v4_q;
    pa5_q  <= pa4_q;
    t5_q   <= t4_q;

    // Stage 6: position step multiply runs in u_mul_step.
    ctl6_q <= ctl5_q;
    sd6_q  <= sd5_q;
    x6_q   <= x5_q;
    v6_q   <= v5_q;
    pa6_q  <= pa5_q;

    // Stage 7: round the position step, h*h/2 term for Verlet.
    ctl7_q <= ctl6_q;
    sd7_q  <= sd6_q;
    x7_q   <= x6_q;
    v7_q   <= v6_q;
    pa7_q  <= pa6_q;
    c7_q   <= rnd_sat(xc_prod, xc_neg, ctl6_q.verlet_pos);

    // Stage 8: Verlet adds h*v to the acceleration term.
    ctl8_q <= ctl7_q;
    sd8_q  <= sd7_q;
    x8_q   <= x7_q;
    v8_q   <= v7_q;
    t8_q   <= ctl7_q.verlet_pos ? sat_add(pa7_q, c7_q) : c7_q;

    // Output register.
    res_q.new_position <= ctl8_q.upd_x ? sat_add(x8_q, t8_q) : x8_q;
    res_q.new_velocity <= v8_q;
    res_q.tag_out      <= sd8_q.tag;
    res_q.last_out     <= sd8_q.last;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // Every request taken into stage 1 comes out with a result strobe.
  `PIS_ASSERT(a_latency, clk_i, rst_ni, vld_q[0] |-> ##8 done_o, "result strobe missing")
  // No result follows a cycle spent in reset.
  `PIS_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !done_o, "result during reset")
  // Kick and damping never both apply; a half kick never moves the position.
  `PIS_ASSERT(a_ctl_excl, clk_i, rst_ni, vld_q[0] |-> !(ctl1_q.kick_v && ctl1_q.damp_v) && !(ctl1_q.upd_x && ctl1_q.half_kick), "conflicting control decode")
  // A position that is not advanced reaches the result unchanged.
  `PIS_ASSERT(a_x_hold, clk_i, rst_ni, vld_q[0] && !ctl1_q.upd_x |-> ##8 res_o.new_position == $past(x1_q, 8), "held position altered")
  // A velocity that is neither kicked nor damped reaches the result unchanged.
  `PIS_ASSERT(a_v_hold, clk_i, rst_ni, vld_q[0] && !ctl1_q.kick_v && !ctl1_q.damp_v |-> ##8 res_o.new_velocity == $past(v1_q, 8), "held velocity altered")

endmodule

/* tb/particle_integrator_step_tb.sv */
`timescale 1ns / 1ps

module particle_integrator_step_tb;
  import pis_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_PAD   = 16;
  localparam int SEGMENTS    = 12;
  localparam int SEG_ITEMS   = 160;

  // Register index with no register behind it; writes to it must change nothing.
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam ufrac_t     INV_MAX   = {UFRAC_W{1'b1}};

  // One row of the directed table. Where typed is set, the wanted values are
  // taken from the row instead of the predictor.
  typedef struct {
    method_e meth;
    step_t   step;
    logic    func;
    word_t   pos;
    word_t   vel;
    word_t   frc;
    ufrac_t  invm;
    logic    pin;
    tag_t    tag;
    logic    lst;
    bit      typed;
    word_t   x_want;
    word_t   v_want;
  } vec_t;

  logic   clk_i = 1'b0;
  logic   rst_ni;
  logic   start_i;
  logic   busy_o;
  in_t    req_i;
  logic   done_o;
  out_t   res_o;
  logic   cfg_we_i;
  logic [1:0] cfg_idx_i;
  ufrac_t cfg_wdata_i;

  // Shadow copy of the configuration registers.
  method_e meth_q  = METHOD_RST;
  step_t   step_q  = STEP_RST;
  ufrac_t  gamma_q = GAMMA_RST;

  out_t due_updates[$];
  int   mismatch_cnt = 0;
  int   cyc_cnt = 0;
  vec_t dir_tab [22];

  particle_integrator_step u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // Signed word times unsigned factor, shifted right by sh, rounded to
  // nearest with ties away from zero, then clamped to the word range.
  function automatic word_t fx_mul(input word_t a, input ufrac_t b, input int sh);
    logic [31:0] mag;
    logic [63:0] q;
    word_t r;
    mag = a[WORD_BITS-1] ? 32'(-a) : 32'(a);
    q   = ({32'd0, mag} * {33'd0, b} + (64'd1 << (sh - 1))) >> sh;
    if (a[WORD_BITS-1]) r = (q > 64'h8000_0000) ? SMIN : -word_t'(q[31:0]);
    else                r = (q > 64'h7FFF_FFFF) ? SMAX : word_t'(q[31:0]);
    return r;
  endfunction

  function automatic word_t fx_add(input word_t a, input word_t b);
    longint s;
    word_t  r;
    s = longint'(a) + longint'(b);
    if (s > longint'(SMAX))      r = SMAX;
    else if (s < longint'(SMIN)) r = SMIN;
    else                         r = word_t'(s);
    return r;
  endfunction

  function automatic word_t fx_neg(input word_t a);
    return (a == SMIN) ? SMAX : -a;
  endfunction

  // Advances one particle component by one time step under the current settings.
  function automatic out_t integrate(input in_t r);
    word_t  x;
    word_t  v;
    word_t  acc;
    ufrac_t h;
    out_t   o;
    x = r.position;
    v = r.velocity;
    h = ufrac_t'(step_q);
    if (!r.fixed) begin
      acc = fx_mul(r.force_req, r.inv_mass, FRAC_BITS);
      case (meth_q)
        M_SYMP: begin
          v = fx_add(v, fx_mul(acc, h, FRAC_BITS));
          x = fx_add(x, fx_mul(v, h, FRAC_BITS));
        end
        M_VERLET: begin
          if (!r.func) begin
            x = fx_add(x, fx_add(fx_mul(v, h, FRAC_BITS),
                                 fx_mul(fx_mul(acc, h, FRAC_BITS), h,
                                        FRAC_BITS + 1)));
          end else begin
            v = fx_add(v, fx_mul(acc, h, FRAC_BITS + 1));
          end
        end
        M_FIRST: begin
          x = fx_add(x, fx_mul(v, h, FRAC_BITS));
        end
        default: begin
          v = fx_neg(fx_mul(r.force_req, gamma_q, FRAC_BITS));
          x = fx_add(x, fx_mul(v, h, FRAC_BITS));
        end
      endcase
    end
    o.new_position = x;
    o.new_velocity = v;
    o.tag_out      = r.item_tag;
    o.last_out     = r.last;
    return o;
  endfunction

  // Mostly moderate magnitudes so that results do not all saturate, with
  // full-range words and the extremes mixed in.
  function automatic word_t rand_word();
    word_t w;
    w = word_t'($urandom);
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       w = SMAX;
          1:       w = SMIN;
          2:       w = 32'sh0;
          default: w = 32'shFFFF_FFFF;
        endcase
      end
      1, 2, 3: begin
      end
      default: w = w >>> $urandom_range(8, 28);
    endcase
    return w;
  endfunction

  function automatic ufrac_t rand_ufrac();
    ufrac_t u;
    u = ufrac_t'($urandom);
    case ($urandom_range(0, 7))
      0:       u = '0;
      1:       u = INV_MAX;
      2, 3: begin
      end
      default: u = ufrac_t'($urandom_range(0, 32'h0004_0000));
    endcase
    return u;
  endfunction

  function automatic in_t rand_request();
    in_t r;
    r.func      = 1'($urandom_range(0, 1));
    r.position  = rand_word();
    r.velocity  = rand_word();
    r.force_req = rand_word();
    r.inv_mass  = rand_ufrac();
    r.fixed     = ($urandom_range(0, 7) == 0);
    r.item_tag  = tag_t'($urandom);
    r.last      = ($urandom_range(0, 15) == 0);
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 50) $display("mismatch: %s", msg);
  endtask

  // Waits until every outstanding request has produced its result.
  task automatic drain();
    start_i <= 1'b0;
    while (due_updates.size() != 0) @(negedge clk_i);
    repeat (DRAIN_PAD) @(negedge clk_i);
  endtask

  // One register write; the shadow follows once the write edge has passed.
  task automatic cfg_write(input logic [1:0] idx, input ufrac_t data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_METHOD: meth_q  = method_e'(data[1:0]);
      CFG_STEP:   step_q  = data[STEP_W-1:0];
      CFG_GAMMA:  gamma_q = data;
      default: begin
      end
    endcase
    @(negedge clk_i);
  endtask

  // Settles the block, then writes every register. Unused data bits carry
  // random values, since the block must ignore them.
  task automatic apply_setting(input method_e m, input step_t s, input ufrac_t g);
    ufrac_t d;
    drain();
    d = ufrac_t'($urandom);
    d[1:0] = m;
    cfg_write(CFG_METHOD, d);
    d = ufrac_t'($urandom);
    d[STEP_W-1:0] = s;
    cfg_write(CFG_STEP, d);
    cfg_write(CFG_GAMMA, g);
    cfg_write(CFG_SPARE, ufrac_t'($urandom));
  endtask

  // Presents one request, holds it until taken, then records what it should give.
  task automatic send_request(input in_t r, input bit typed, input word_t xw,
                              input word_t vw, input int idle_pct);
    out_t want;
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      req_i   <= rand_request();
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    if (typed) want = '{new_position: xw, new_velocity: vw,
                        tag_out: r.item_tag, last_out: r.last};
    else       want = integrate(r);
    @(negedge clk_i);
    due_updates.push_back(want);
  endtask

  // Result checking and the overall cycle limit.
  always @(posedge clk_i) begin : res_check
    out_t want;
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("[particle_integrator_step] ERROR");
      $finish;
    end else if (rst_ni && done_o) begin
      if (due_updates.size() == 0) begin
        flag_mismatch($sformatf("result with nothing outstanding, tag %h", res_o.tag_out));
      end else begin
        want = due_updates.pop_front();
        if (res_o.new_position !== want.new_position)
          flag_mismatch($sformatf("tag %h: new_position %h, want %h", want.tag_out,
                                  res_o.new_position, want.new_position));
        if (res_o.new_velocity !== want.new_velocity)
          flag_mismatch($sformatf("tag %h: new_velocity %h, want %h", want.tag_out,
                                  res_o.new_velocity, want.new_velocity));
        if (res_o.tag_out !== want.tag_out)
          flag_mismatch($sformatf("tag_out %h, want %h", res_o.tag_out, want.tag_out));
        if (res_o.last_out !== want.last_out)
          flag_mismatch($sformatf("tag %h: last_out %b, want %b", want.tag_out,
                                  res_o.last_out, want.last_out));
      end
    end
  end

  initial begin : stim
    vec_t   row;
    in_t    r;
    step_t  s;
    ufrac_t g;
    int     idle_pct;

    rst_ni      = 1'b0;
    start_i     = 1'b0;
    req_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_METHOD;
    cfg_wdata_i = '0;

    // Directed requests: extremes, pinned particles, each method and pass,
    // rounding ties in both signs and saturation in both directions.
    dir_tab = '{
      '{M_SYMP,   16'd655,   1'b0, 32'sh0, 32'sh0, 32'sh0, 31'h0, 1'b0,
        16'h0000, 1'b0, 1'b1, 32'sh0, 32'sh0},
      '{M_SYMP,   16'd655,   1'b0, SMAX, SMIN, SMAX, INV_MAX, 1'b1,
        16'hFFFF, 1'b1, 1'b1, SMAX, SMIN},
      '{M_SYMP,   16'd655,   1'b0, SMAX, SMAX, SMAX, INV_MAX, 1'b0,
        16'h0001, 1'b0, 1'b1, SMAX, SMAX},
      '{M_SYMP,   16'd655,   1'b1, SMIN, SMIN, SMIN, INV_MAX, 1'b0,
        16'h8000, 1'b1, 1'b1, SMIN, SMIN},
      '{M_SYMP,   16'd655,   1'b0, 32'sh0003_0000, 32'sh0000_8000, 32'shFFFE_0000,
        31'h0000_8000, 1'b0, 16'h0005, 1'b0, 1'b0, 32'sh0, 32'sh0},
      '{M_SYMP,   16'd0,     1'b0, 32'sh1234_5678, 32'shFFFF_0001, 32'sh7000_0000,
        31'h0001_0000, 1'b0, 16'h0006, 1'b0, 1'b1, 32'sh1234_5678, 32'shFFFF_0001},
      '{M_SYMP,   16'd65535, 1'b0, 32'shFFF0_0000, 32'sh0020_0000, 32'sh0100_0000,
        31'h0000_4000, 1'b0, 16'h0007, 1'b0, 1'b0, 32'sh0, 32'sh0},
      '{M_VERLET, 16'd655,   1'b0, 32'sh0001_8000, 32'shFFFF_C000, 32'sh0004_0000,
        31'h0002_0000, 1'b0, 16'h0008, 1'b0, 1'b0, 32'sh0, 32'sh0},
      '{M_VERLET, 16'd655,   1'b1, 32'sh0001_8000, 32'shFFFF_C000, 32'sh0004_0000,
        31'h0002_0000, 1'b0, 16'h0009, 1'b0, 1'b0, 32'sh0, 32'sh0},
      '{M_VERLET, 16'd655,   1'b0, 32'sh0010_0000, 32'sh0, 32'sh0, INV_MAX, 1'b0,
        16'h000A, 1'b0, 1'b1, 32'sh0010_0000, 32'sh0},
      '{M_VERLET, 16'd655,   1'b1, 32'sh0123_4567, 32'shFEDC_BA98, 32'sh0FFF_0000,
        31'h0001_0000, 1'b1, 16'h000B, 1'b1, 1'b1, 32'sh0123_4567, 32'shFEDC_BA98},
      '{M_VERLET, 16'd65535, 1'b0, SMAX, SMAX, SMAX, INV_MAX, 1'b0,
        16'h000C, 1'b0, 1'b1, SMAX, SMAX},
      '{M_VERLET, 16'd65535, 1'b1, SMIN, SMIN, SMIN, INV_MAX, 1'b0,
        16'h000D, 1'b0, 1'b1, SMIN, SMIN},
      '{M_FIRST,  16'd32768, 1'b0, 32'sh0, 32'sh1, 32'sh0055_0000,
        31'h0001_0000, 1'b0, 16'h000E, 1'b0, 1'b1, 32'sh1, 32'sh1},
      '{M_FIRST,  16'd32768, 1'b1, 32'sh0, 32'shFFFF_FFFF, 32'shFF00_0000,
        31'h0000_0100, 1'b0, 16'h000F, 1'b1, 1'b1, 32'shFFFF_FFFF, 32'shFFFF_FFFF},
      '{M_FIRST,  16'd655,   1'b0, 32'sh7FFF_FFFE, SMAX, 32'sh0, 31'h0, 1'b0,
        16'h0010, 1'b0, 1'b1, SMAX, SMAX},
      '{M_FIRST,  16'd655,   1'b1, 32'shFFF8_0000, 32'sh0003_2000, 32'sh0001_0000,
        31'h0001_0000, 1'b0, 16'h0011, 1'b0, 1'b0, 32'sh0, 32'sh0},
      '{M_DAMP,   16'd655,   1'b0, 32'sh0002_0000, 32'sh1111_1111, 32'sh0,
        31'h0001_0000, 1'b0, 16'h0012, 1'b0, 1'b1, 32'sh0002_0000, 32'sh0},
      '{M_DAMP,   16'd655,   1'b1, 32'sh0, 32'sh0, SMIN, 31'h0, 1'b0,
        16'h0013, 1'b0, 1'b0, 32'sh0, 32'sh0},
      '{M_DAMP,   16'd655,   1'b0, 32'sh0000_4000, 32'sh0, 32'shFFFC_8000,
        31'h0001_0000, 1'b0, 16'h0014, 1'b0, 1'b0, 32'sh0, 32'sh0},
      '{M_DAMP,   16'd655,   1'b1, 32'sh7654_3210, 32'sh89AB_CDEF, SMAX, INV_MAX, 1'b1,
        16'h0015, 1'b1, 1'b1, 32'sh7654_3210, 32'sh89AB_CDEF},
      '{M_DAMP,   16'd655,   1'b0, SMIN, 32'sh0001_0000, SMAX, 31'h0001_0000, 1'b0,
        16'hFFFE, 1'b1, 1'b1, SMIN, 32'sh8000_0001}
    };

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, with the settings changed only where a row asks for it.
    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      if (row.meth != meth_q || row.step != step_q) apply_setting(row.meth, row.step, gamma_q);
      r.func      = row.func;
      r.position  = row.pos;
      r.velocity  = row.vel;
      r.force_req = row.frc;
      r.inv_mass  = row.invm;
      r.fixed     = row.pin;
      r.item_tag  = row.tag;
      r.last      = row.lst;
      send_request(r, row.typed, row.x_want, row.v_want, 0);
    end

    // Random part: every method under each idling pattern, with extreme
    // step sizes and friction settings spread over the segments.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        1, 4, 6: s = 16'hFFFF;
        2, 9:    s = '0;
        5:       s = 16'd1;
        default: s = step_t'($urandom);
      endcase
      case (seg)
        3:       g = INV_MAX;
        7:       g = '0;
        11:      g = ufrac_t'($urandom);
        default: g = ufrac_t'($urandom_range(0, 32'h0004_0000));
      endcase
      apply_setting(method_e'(seg % 4), s, g);
      idle_pct = (seg < 4) ? 27 : (seg < 8) ? 57 : 0;
      repeat (SEG_ITEMS) send_request(rand_request(), 1'b0, 32'sh0, 32'sh0, idle_pct);
    end

    drain();
    if (mismatch_cnt == 0) begin
      $display("[particle_integrator_step] OK");
    end else begin
      $display("[particle_integrator_step] ERROR");
    end
    $finish;
  end

endmodule
